FILE: sv/ddds_pkg.sv
// ddds_pkg: types, register codes and constants shared by the display sequencer
// used by ddds_front, ddds_back and decimal_digit_display_sequencer
// no dependencies
package ddds_pkg;

  localparam int NUM_DIGITS_DEF = 6;

  // frame index width, covers 5 + NUM_DIGITS frames for NUM_DIGITS up to 8
  localparam int STEP_W = 4;

  localparam int VALUE_W = 32;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 8;
  localparam int DIGIT_W = 4;

  localparam int QDEPTH = 2;

  // opcode of an input item
  localparam logic OP_INIT = 1'b0;
  localparam logic OP_SHOW = 1'b1;

  // configuration register indexes
  localparam logic CFG_INTENSITY  = 1'b0;
  localparam logic CFG_SCAN_DEPTH = 1'b1;

  localparam logic [3:0] INTENSITY_RST  = 4'd7;
  localparam logic [2:0] SCAN_DEPTH_RST = 3'd5;

  // controller register addresses
  localparam logic [ADDR_W-1:0] ADDR_DIGIT0    = 4'h1;
  localparam logic [ADDR_W-1:0] ADDR_DECODE    = 4'h9;
  localparam logic [ADDR_W-1:0] ADDR_INTENSITY = 4'hA;
  localparam logic [ADDR_W-1:0] ADDR_SCANLIM   = 4'hB;
  localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN  = 4'hC;
  localparam logic [ADDR_W-1:0] ADDR_TEST      = 4'hF;

  localparam logic [DATA_W-1:0] DATA_DECODE_ALL = 8'hFF;
  localparam logic [DATA_W-1:0] DATA_SHUTDOWN   = 8'h01;
  localparam logic [DATA_W-1:0] DATA_TEST_OFF   = 8'h00;
  localparam logic [DATA_W-1:0] CODE_BLANK      = 8'h0F;

  // setup frames before the digit blanking frames
  localparam int INIT_FIXED = 5;

  // floor(v / 10) = (v * RECIP_10) >> RECIP_SHIFT for any 32-bit v
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCCCCCD;
  localparam int                 RECIP_SHIFT = 35;

  typedef struct packed {
    logic               show;
    logic [VALUE_W-1:0] value;
    logic [STEP_W-1:0]  last_step;
  } cmd_t;

endpackage

FILE: sv/ddds_front.sv
// ddds_front: accepts input items, classifies them into frame commands and
// holds them in a two-entry queue for the back end; uses ddds_pkg
module ddds_front #(
  parameter int NUM_DIGITS = ddds_pkg::NUM_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ddds_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
  input  logic                          s_tuser,   // [0] opcode
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output ddds_pkg::cmd_t                cmd
);

  localparam int PTR_W  = $clog2(ddds_pkg::QDEPTH);
  localparam int FILL_W = $clog2(ddds_pkg::QDEPTH + 1);

  localparam logic [ddds_pkg::STEP_W-1:0] SHOW_LAST =
    ddds_pkg::STEP_W'(NUM_DIGITS - 1);
  localparam logic [ddds_pkg::STEP_W-1:0] INIT_LAST =
    ddds_pkg::STEP_W'(NUM_DIGITS + ddds_pkg::INIT_FIXED - 1);

  ddds_pkg::cmd_t    q_mem [ddds_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  ddds_pkg::cmd_t    entry;
  logic              push;
  logic              pop;

  assign s_tready  = (fill != FILL_W'(ddds_pkg::QDEPTH));
  assign cmd_valid = (fill != '0);
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_mem[rd_ptr];

  always_comb begin
    entry.show      = (s_tuser == ddds_pkg::OP_SHOW);
    entry.value     = s_tdata;
    entry.last_step = entry.show ? SHOW_LAST : INIT_LAST;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

FILE: sv/ddds_back.sv
// ddds_back: walks one command frame by frame, splits decimal digits with a
// reciprocal multiply and drives the registered output beat; uses ddds_pkg
module ddds_back #(
  parameter int NUM_DIGITS = ddds_pkg::NUM_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  ddds_pkg::cmd_t                cmd,
  input  logic [3:0]                    intensity,
  input  logic [2:0]                    scan_depth,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // [3:0] reg_address, [11:4] reg_data
  output logic                          m_tlast    // last
);

  localparam int HI_CNT = NUM_DIGITS / 2;
  localparam int LO_CNT = NUM_DIGITS - HI_CNT;
  localparam int VW     = ddds_pkg::VALUE_W;
  localparam int SW     = ddds_pkg::STEP_W;
  localparam int AW     = ddds_pkg::ADDR_W;
  localparam int DW     = ddds_pkg::DATA_W;

  logic                busy;
  logic                show;
  logic [VW-1:0]       value;
  logic [SW-1:0]       step;
  logic [SW-1:0]       last_step;

  logic                advance;
  logic                emit;
  logic                at_last;
  logic                load;
  logic [2*VW-1:0]     prod;
  logic [VW-1:0]       quot;
  logic [VW-1:0]       rem;
  logic [AW-1:0]       frame_addr;
  logic [DW-1:0]       frame_data;
  logic [AW-1:0]       out_addr;
  logic [DW-1:0]       out_data;

  assign advance   = !m_tvalid || m_tready;
  assign emit      = busy && advance;
  assign at_last   = (step == last_step);
  assign cmd_ready = !busy || (emit && at_last);
  assign load      = cmd_valid && cmd_ready;

  // divide by ten through the reciprocal, remainder by shift-and-add
  assign prod = {{VW{1'b0}}, value} * {{VW{1'b0}}, ddds_pkg::RECIP_10};
  assign quot = VW'(prod >> ddds_pkg::RECIP_SHIFT);
  assign rem  = value - ((quot << 3) + (quot << 1));

  always_comb begin
    frame_addr = '0;
    frame_data = '0;
    if (show) begin
      // low digits fill the upper registers first
      if (step < SW'(LO_CNT)) begin
        frame_addr = AW'(HI_CNT) + ddds_pkg::ADDR_DIGIT0 + AW'(step);
      end else begin
        frame_addr = AW'(step) - AW'(LO_CNT) + ddds_pkg::ADDR_DIGIT0;
      end
      frame_data = DW'(rem[ddds_pkg::DIGIT_W-1:0]);
    end else begin
      unique case (step)
        SW'(0): begin
          frame_addr = ddds_pkg::ADDR_DECODE;
          frame_data = ddds_pkg::DATA_DECODE_ALL;
        end
        SW'(1): begin
          frame_addr = ddds_pkg::ADDR_SCANLIM;
          frame_data = DW'(scan_depth);
        end
        SW'(2): begin
          frame_addr = ddds_pkg::ADDR_INTENSITY;
          frame_data = DW'(intensity);
        end
        SW'(3): begin
          frame_addr = ddds_pkg::ADDR_SHUTDOWN;
          frame_data = ddds_pkg::DATA_SHUTDOWN;
        end
        SW'(4): begin
          frame_addr = ddds_pkg::ADDR_TEST;
          frame_data = ddds_pkg::DATA_TEST_OFF;
        end
        default: begin
          frame_addr = AW'(step) - AW'(ddds_pkg::INIT_FIXED) + ddds_pkg::ADDR_DIGIT0;
          frame_data = ddds_pkg::CODE_BLANK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      show      <= cmd.show;
      value     <= cmd.value;
      last_step <= cmd.last_step;
    end else if (emit) begin
      value <= quot;
    end
    if (emit) begin
      out_addr <= frame_addr;
      out_data <= frame_data;
      m_tlast  <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        step <= '0;
      end else if (emit) begin
        if (at_last) begin
          busy <= 1'b0;
        end
        step <= step + SW'(1);
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {4'b0, out_data, out_addr};

endmodule

FILE: sv/decimal_digit_display_sequencer.sv
// decimal_digit_display_sequencer: top level, config registers and the
// front/back split; uses ddds_pkg, ddds_front, ddds_back
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  tdata value, tuser opcode
//   m_*       out        m_tvalid/m_tready  tdata reg_address/reg_data, tlast
//   cfg_*     in         cfg_valid/ready    cfg_index, cfg_data
//
// one frame per cycle from the back end while m_tready is high: an init item makes NUM_DIGITS + 5
// frames, a show item NUM_DIGITS frames (one divide-by-ten step per frame)
// the next command loads in the cycle its predecessor's last frame is issued
// a two-entry command queue lets the input side keep accepting while m_tready is low, until both entries are full
// reset is synchronous; config writes are always accepted
module decimal_digit_display_sequencer #(
  parameter int NUM_DIGITS = ddds_pkg::NUM_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ddds_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
  input  logic                          s_tuser,   // [0] opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // [3:0] reg_address, [11:4] reg_data
  output logic                          m_tlast,   // last
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [3:0]                    cfg_data
);

  logic           cmd_valid;
  logic           cmd_ready;
  ddds_pkg::cmd_t cmd;
  logic [3:0]     intensity;
  logic [2:0]     scan_depth;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity  <= ddds_pkg::INTENSITY_RST;
      scan_depth <= ddds_pkg::SCAN_DEPTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ddds_pkg::CFG_INTENSITY:  intensity  <= cfg_data;
        ddds_pkg::CFG_SCAN_DEPTH: scan_depth <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  ddds_front #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  ddds_back #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .intensity  (intensity),
    .scan_depth (scan_depth),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

FILE: dv/decimal_digit_display_sequencer_tb.sv
// decimal_digit_display_sequencer_tb: self-checking bench for the display sequencer
// predicts the register frames of every init and show command and checks each output beat
// depends on ddds_pkg and decimal_digit_display_sequencer
`timescale 1ns / 100ps

module decimal_digit_display_sequencer_tb;

  localparam int NDIG        = ddds_pkg::NUM_DIGITS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic [ddds_pkg::ADDR_W-1:0] addr;
    logic [ddds_pkg::DATA_W-1:0] data;
    logic                        last;
  } frame_t;

  typedef struct packed {
    logic                         op;
    logic [ddds_pkg::VALUE_W-1:0] value;
  } display_cmd_t;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [ddds_pkg::VALUE_W-1:0] s_tdata;   // [31:0] value
  logic                         s_tuser;   // [0] opcode
  logic                         m_tvalid;
  logic                         m_tready;
  logic [15:0]                  m_tdata;   // [3:0] reg_address, [11:4] reg_data
  logic                         m_tlast;   // last
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic                         cfg_index;
  logic [3:0]                   cfg_data;

  display_cmd_t pending_cmds[$];
  frame_t       frames_due[$];

  logic [3:0] intensity_q;
  logic [2:0] scan_depth_q;
  logic       src_beat;
  logic       cfg_beat;
  logic       steady;
  int         src_gap;
  int         sink_stall;
  int         cycle_count;
  int         mismatches;

  decimal_digit_display_sequencer #(
    .NUM_DIGITS(NDIG)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic frame_t mk_frame(input logic [ddds_pkg::ADDR_W-1:0] addr,
                                      input logic [ddds_pkg::DATA_W-1:0] data);
    frame_t f;
    f.addr = addr;
    f.data = data;
    f.last = 1'b0;
    return f;
  endfunction

  // frames one command produces under the current register settings
  task automatic predict_frames(input logic op, input logic [ddds_pkg::VALUE_W-1:0] value);
    frame_t      burst[$];
    logic [31:0] rest;
    int          half_n;
    rest   = value;
    half_n = NDIG / 2;
    if (op == ddds_pkg::OP_INIT) begin
      burst.push_back(mk_frame(ddds_pkg::ADDR_DECODE, ddds_pkg::DATA_DECODE_ALL));
      burst.push_back(mk_frame(ddds_pkg::ADDR_SCANLIM, {5'd0, scan_depth_q}));
      burst.push_back(mk_frame(ddds_pkg::ADDR_INTENSITY, {4'd0, intensity_q}));
      burst.push_back(mk_frame(ddds_pkg::ADDR_SHUTDOWN, ddds_pkg::DATA_SHUTDOWN));
      burst.push_back(mk_frame(ddds_pkg::ADDR_TEST, ddds_pkg::DATA_TEST_OFF));
      for (int i = 0; i < NDIG; i++) begin
        burst.push_back(mk_frame(ddds_pkg::ADDR_DIGIT0 + 4'(i), ddds_pkg::CODE_BLANK));
      end
    end else begin
      // low digits land on the upper registers, the rest on registers from 1 up
      for (int i = 0; i < NDIG - half_n; i++) begin
        burst.push_back(mk_frame(ddds_pkg::ADDR_DIGIT0 + 4'(half_n + i), 8'(rest % 10)));
        rest = rest / 10;
      end
      for (int i = 0; i < half_n; i++) begin
        burst.push_back(mk_frame(ddds_pkg::ADDR_DIGIT0 + 4'(i), 8'(rest % 10)));
        rest = rest / 10;
      end
    end
    burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) frames_due.push_back(burst[i]);
  endtask

  // sample side: predictor, register shadow and frame check
  always @(posedge clk) begin
    frame_t want;
    if (rst) begin
      src_beat     <= 1'b0;
      cfg_beat     <= 1'b0;
      intensity_q  = ddds_pkg::INTENSITY_RST;
      scan_depth_q = ddds_pkg::SCAN_DEPTH_RST;
    end else begin
      src_beat <= s_tvalid && s_tready;
      cfg_beat <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ddds_pkg::CFG_INTENSITY) intensity_q = cfg_data;
        else scan_depth_q = cfg_data[2:0];
      end
      if (s_tvalid && s_tready) predict_frames(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (frames_due.size() == 0) begin
          report_mismatch($sformatf("unexpected frame addr %h data %h last %b",
                                    m_tdata[3:0], m_tdata[11:4], m_tlast));
        end else begin
          want = frames_due.pop_front();
          if (m_tdata[3:0] !== want.addr)
            report_mismatch($sformatf("reg_address %h, wanted %h", m_tdata[3:0], want.addr));
          if (m_tdata[11:4] !== want.data)
            report_mismatch($sformatf("reg_data %h, wanted %h (addr %h)",
                                      m_tdata[11:4], want.data, want.addr));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last %b, wanted %b (addr %h)",
                                      m_tlast, want.last, want.addr));
        end
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    display_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap  = 0;
    end else if (!s_tvalid || src_beat) begin
      if (src_gap > 0) begin
        s_tvalid <= 1'b0;
        src_gap--;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= c.value;
        src_gap  = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // frame sink with random back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      sink_stall = 0;
    end else if (sink_stall > 0) begin
      m_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_tready   <= 1'b1;
      sink_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames outstanding",
               cycle_count, frames_due.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [3:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_beat);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_cmd(input logic op, input logic [ddds_pkg::VALUE_W-1:0] value);
    display_cmd_t c;
    c.op    = op;
    c.value = value;
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    while (!(pending_cmds.size() == 0 && !s_tvalid && frames_due.size() == 0))
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [ddds_pkg::VALUE_W-1:0] pick_value();
    logic [31:0] p10;
    int          k;
    p10 = 1;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 999999);
      2: begin
        // around a power of ten, where digits roll over
        k = $urandom_range(0, 9);
        for (int j = 0; j < k; j++) p10 = p10 * 10;
        return p10 + $urandom_range(0, 2) - 1;
      end
      3: return $urandom_range(0, 99);
      4: return 32'hFFFF_FFFF - $urandom_range(0, 5000);
      default: return $urandom_range(1000000, 99999999);
    endcase
  endfunction

  task automatic set_phase_regs(input logic [3:0] inten, input logic [3:0] scan);
    if ($urandom_range(0, 1)) begin
      write_reg(ddds_pkg::CFG_INTENSITY, inten);
      write_reg(ddds_pkg::CFG_SCAN_DEPTH, scan);
    end else begin
      write_reg(ddds_pkg::CFG_SCAN_DEPTH, scan);
      write_reg(ddds_pkg::CFG_INTENSITY, inten);
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = ddds_pkg::OP_INIT;
    m_tready     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = ddds_pkg::CFG_INTENSITY;
    cfg_data     = '0;
    steady       = 1'b0;
    src_gap      = 0;
    sink_stall   = 0;
    cycle_count  = 0;
    mismatches   = 0;
    intensity_q  = ddds_pkg::INTENSITY_RST;
    scan_depth_q = ddds_pkg::SCAN_DEPTH_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, digit rollover, dropped high digits, value extremes
    queue_cmd(ddds_pkg::OP_INIT, 32'h0);
    queue_cmd(ddds_pkg::OP_INIT, 32'hFFFF_FFFF);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd0);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd999999);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd1000000);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd123456);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd654321);
    queue_cmd(ddds_pkg::OP_SHOW, 32'hFFFF_FFFF);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd1);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd10);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd100);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd1000);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd10000);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd100000);
    queue_cmd(ddds_pkg::OP_SHOW, 32'hAAAA_AAAA);
    queue_cmd(ddds_pkg::OP_SHOW, 32'h5555_5555);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd999);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd1999999);
    queue_cmd(ddds_pkg::OP_INIT, 32'h1234_5678);
    queue_cmd(ddds_pkg::OP_SHOW, 32'd4000000009);
    drain();

    for (int p = 0; p < 6; p++) begin
      // top settings, bottom settings, then wide writes that get truncated, then random
      case (p)
        0: set_phase_regs(4'hF, 4'hF);
        1: set_phase_regs(4'h0, 4'h0);
        2: set_phase_regs(4'($urandom_range(0, 15)), 4'h8);
        default: set_phase_regs(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      steady = (p == 3);
      queue_cmd(ddds_pkg::OP_INIT, $urandom);
      for (int i = 0; i < 59; i++) begin
        if ($urandom_range(0, 4) == 0) queue_cmd(ddds_pkg::OP_INIT, $urandom);
        else queue_cmd(ddds_pkg::OP_SHOW, pick_value());
      end
      drain();
    end

    steady = 1'b0;
    repeat (20) @(negedge clk);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
